// ===== hdl/ugbi_pkg.sv =====
// Shared types and codes of the uniform grid bilinear interpolator.
package ugbi_pkg;

  localparam logic [1:0] ACT_WR_TABLE = 2'd0;
  localparam logic [1:0] ACT_WR_GEOM  = 2'd1;
  localparam logic [1:0] ACT_LOOK_1D  = 2'd2;
  localparam logic [1:0] ACT_LOOK_2D  = 2'd3;

  localparam logic [2:0] GEOM_E_ORIGIN = 3'd0;
  localparam logic [2:0] GEOM_E_INV    = 3'd1;
  localparam logic [2:0] GEOM_E_LEN    = 3'd2;
  localparam logic [2:0] GEOM_D_ORIGIN = 3'd3;
  localparam logic [2:0] GEOM_D_INV    = 3'd4;
  localparam logic [2:0] GEOM_D_LEN    = 3'd5;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam int FRAC_W = 50;

  typedef logic signed [FRAC_W-1:0] frac_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_TABLE_WR,
    KIND_GEOM_WR,
    KIND_LOOK_1D,
    KIND_LOOK_2D
  } kind_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         table_sel;
    logic [5:0]         row_index;
    logic [7:0]         col_index;
    logic [2:0]         geom_field;
    logic signed [31:0] write_value;
    logic signed [31:0] energy;
    logic signed [31:0] density;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         action_done;
  } out_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         action;
    logic [1:0]         table_sel;
    logic [5:0]         row_index;
    logic [7:0]         col_index;
    logic [2:0]         geom_field;
    logic signed [31:0] write_value;
    logic signed [31:0] energy;
    logic signed [31:0] density;
  } cmd_t;

endpackage

// ===== hdl/ugbi_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
module ugbi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(do_pop);
    end
  end

endmodule

// ===== hdl/ugbi_front.sv =====
// Front end: classifies an incoming transaction into an engine command.
module ugbi_front #(
  parameter int NUM_TABLES         = 4,
  parameter int MAX_E_POINTS       = 256,
  parameter int MAX_DENSITY_POINTS = 64
) (
  input  ugbi_pkg::in_item_t item_i,
  output ugbi_pkg::cmd_t     cmd_o
);

  logic tbl_ok, idx_ok, geom_ok;

  assign tbl_ok  = int'(item_i.table_sel) < NUM_TABLES;
  assign idx_ok  = (int'(item_i.row_index) < MAX_DENSITY_POINTS) &&
                   (int'(item_i.col_index) < MAX_E_POINTS);
  assign geom_ok = item_i.geom_field inside {[ugbi_pkg::GEOM_E_ORIGIN:ugbi_pkg::GEOM_D_LEN]};

  always_comb begin
    cmd_o.action      = item_i.action;
    cmd_o.table_sel   = item_i.table_sel;
    cmd_o.row_index   = item_i.row_index;
    cmd_o.col_index   = item_i.col_index;
    cmd_o.geom_field  = item_i.geom_field;
    cmd_o.write_value = item_i.write_value;
    cmd_o.energy      = item_i.energy;
    cmd_o.density     = item_i.density;
    cmd_o.kind        = ugbi_pkg::KIND_NONE;
    case (item_i.action)
      ugbi_pkg::ACT_WR_TABLE: begin
        if (tbl_ok && idx_ok) cmd_o.kind = ugbi_pkg::KIND_TABLE_WR;
      end
      ugbi_pkg::ACT_WR_GEOM: begin
        if (tbl_ok && geom_ok) cmd_o.kind = ugbi_pkg::KIND_GEOM_WR;
      end
      ugbi_pkg::ACT_LOOK_1D: begin
        if (tbl_ok) cmd_o.kind = ugbi_pkg::KIND_LOOK_1D;
      end
      ugbi_pkg::ACT_LOOK_2D: begin
        if (tbl_ok) cmd_o.kind = ugbi_pkg::KIND_LOOK_2D;
      end
      default: cmd_o.kind = ugbi_pkg::KIND_NONE;
    endcase
  end

endmodule

// ===== hdl/ugbi_lerp.sv =====
// Four-stage saturating linear interpolation a + floor((b-a)*f / 2^16).
module ugbi_lerp (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  input  ugbi_pkg::frac_t     f_i,
  output logic signed [31:0]  y_o
);

  logic signed [32:0] d1_q;
  logic signed [31:0] a1_q, a2_q, a3_q;
  ugbi_pkg::frac_t    f1_q;
  logic signed [57:0] pl2_q;
  logic signed [58:0] ph2_q;
  logic signed [82:0] s3_q;
  logic signed [66:0] q3;
  logic signed [67:0] v3;
  logic signed [24:0] fl1;
  logic signed [25:0] fh1;

  assign fl1 = $signed({1'b0, f1_q[23:0]});
  assign fh1 = f1_q[49:24];
  assign q3  = s3_q[82:16];
  assign v3  = 68'(q3) + 68'(a3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q  <= 33'(b_i) - 33'(a_i);
      a1_q  <= a_i;
      f1_q  <= f_i;
      pl2_q <= 58'(d1_q) * 58'(fl1);
      ph2_q <= 59'(d1_q) * 59'(fh1);
      a2_q  <= a1_q;
      s3_q  <= (83'(ph2_q) <<< 24) + 83'(pl2_q);
      a3_q  <= a2_q;
      if (v3 > 68'sd2147483647) begin
        y_o <= 32'sh7FFFFFFF;
      end else if (v3 < -68'sd2147483648) begin
        y_o <= 32'sh80000000;
      end else begin
        y_o <= v3[31:0];
      end
    end
  end

endmodule

// ===== hdl/ugbi_engine.sv =====
// Back end: geometry, cell location, banked table memory and interpolation pipeline.
module ugbi_engine #(
  parameter int NUM_TABLES         = 4,
  parameter int MAX_E_POINTS       = 256,
  parameter int MAX_DENSITY_POINTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ugbi_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  logic                res_ready_i,
  output logic                res_push_o,
  output ugbi_pkg::out_item_t res_o
);

  localparam int TW  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int EIW = $clog2(MAX_E_POINTS);
  localparam int DIW = $clog2(MAX_DENSITY_POINTS);
  localparam int ECW = $clog2(MAX_E_POINTS + 1);
  localparam int DCW = $clog2(MAX_DENSITY_POINTS + 1);
  localparam int EHW = (EIW > 1) ? EIW - 1 : 1;
  localparam int DHW = (DIW > 1) ? DIW - 1 : 1;
  localparam int AW  = TW + DHW + EHW;
  localparam logic signed [31:0] E_MAX_S = 32'(MAX_E_POINTS);
  localparam logic signed [31:0] D_MAX_S = 32'(MAX_DENSITY_POINTS);

  logic adv;
  assign adv       = res_ready_i;
  assign cmd_pop_o = cmd_valid_i && adv;

  // geometry
  logic signed [31:0] e_org_q [NUM_TABLES];
  logic signed [31:0] e_inv_q [NUM_TABLES];
  logic signed [31:0] d_org_q [NUM_TABLES];
  logic signed [31:0] d_inv_q [NUM_TABLES];
  logic [ECW-1:0]     e_cnt_q [NUM_TABLES];
  logic [DCW-1:0]     d_cnt_q [NUM_TABLES];

  logic [TW-1:0]      h_tbl;
  logic signed [31:0] wv;
  logic [ECW-1:0]     e_len;
  logic [DCW-1:0]     d_len;

  assign h_tbl = TW'(cmd_i.table_sel);
  assign wv    = cmd_i.write_value;
  assign e_len = (wv < 32'sd2) ? ECW'(2) : (wv > E_MAX_S) ? ECW'(MAX_E_POINTS) : wv[ECW-1:0];
  assign d_len = (wv < 32'sd2) ? DCW'(2) :
                 (wv > D_MAX_S) ? DCW'(MAX_DENSITY_POINTS) : wv[DCW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TABLES; k++) begin
        e_org_q[k] <= '0;
        e_inv_q[k] <= ugbi_pkg::ONE_Q16;
        e_cnt_q[k] <= ECW'(2);
        d_org_q[k] <= '0;
        d_inv_q[k] <= ugbi_pkg::ONE_Q16;
        d_cnt_q[k] <= DCW'(2);
      end
    end else if (cmd_pop_o && cmd_i.kind == ugbi_pkg::KIND_GEOM_WR) begin
      case (cmd_i.geom_field)
        ugbi_pkg::GEOM_E_ORIGIN: e_org_q[h_tbl] <= wv;
        ugbi_pkg::GEOM_E_INV:    e_inv_q[h_tbl] <= wv;
        ugbi_pkg::GEOM_E_LEN:    e_cnt_q[h_tbl] <= e_len;
        ugbi_pkg::GEOM_D_ORIGIN: d_org_q[h_tbl] <= wv;
        ugbi_pkg::GEOM_D_INV:    d_inv_q[h_tbl] <= wv;
        ugbi_pkg::GEOM_D_LEN:    d_cnt_q[h_tbl] <= d_len;
        default: ;
      endcase
    end
  end

  // stage 1: offsets
  logic               v1_q, v2_q, v3_q, v4_q;
  ugbi_pkg::cmd_t     c1_q, c2_q, c3_q;
  logic signed [32:0] de1_q, dd1_q;
  logic signed [31:0] ie1_q, id1_q;
  logic [ECW-1:0]     ce1_q, ce2_q;
  logic [DCW-1:0]     cd1_q, cd2_q;
  logic signed [64:0] pe2_q, pd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= cmd_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q  <= cmd_i;
      de1_q <= 33'(cmd_i.energy) - 33'(e_org_q[h_tbl]);
      dd1_q <= 33'(cmd_i.density) - 33'(d_org_q[h_tbl]);
      ie1_q <= e_inv_q[h_tbl];
      id1_q <= d_inv_q[h_tbl];
      ce1_q <= e_cnt_q[h_tbl];
      cd1_q <= d_cnt_q[h_tbl];
      c2_q  <= c1_q;
      pe2_q <= 65'(de1_q) * 65'(ie1_q);
      pd2_q <= 65'(dd1_q) * 65'(id1_q);
      ce2_q <= ce1_q;
      cd2_q <= cd1_q;
    end
  end

  // stage 3: cell index and fraction
  logic [ECW-1:0]     e_lim;
  logic [DCW-1:0]     d_lim;
  logic [EIW-1:0]     ix_e_d, ix_e3_q;
  logic [DIW-1:0]     ix_d_d, ix_d3_q;
  logic signed [48:0] t_e, t_d;
  ugbi_pkg::frac_t    fr_e_d, fr_d_d, fr_e3_q, fr_d3_q;

  assign e_lim = ce2_q - ECW'(2);
  assign d_lim = cd2_q - DCW'(2);
  assign t_e   = pe2_q[64:16];
  assign t_d   = pd2_q[64:16];

  always_comb begin
    if (pe2_q[64]) ix_e_d = '0;
    else if (pe2_q[63:32] > 32'(e_lim)) ix_e_d = EIW'(e_lim);
    else ix_e_d = EIW'(pe2_q[63:32]);
    if (pd2_q[64] || c2_q.kind != ugbi_pkg::KIND_LOOK_2D) ix_d_d = '0;
    else if (pd2_q[63:32] > 32'(d_lim)) ix_d_d = DIW'(d_lim);
    else ix_d_d = DIW'(pd2_q[63:32]);
    fr_e_d = 50'(t_e) - $signed(50'({ix_e_d, 16'h0000}));
    fr_d_d = 50'(t_d) - $signed(50'({ix_d_d, 16'h0000}));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c3_q    <= c2_q;
      ix_e3_q <= ix_e_d;
      ix_d3_q <= ix_d_d;
      fr_e3_q <= fr_e_d;
      fr_d3_q <= fr_d_d;
    end
  end

  // stage 4: four banks split by row and column parity
  logic [TW-1:0]      t3;
  logic [AW-1:0]      waddr;
  logic               re;
  logic [3:0]         we;
  logic signed [31:0] rd_q [4];
  logic [DIW-1:0]     wrow;
  logic [EIW-1:0]     wcol;

  assign t3    = TW'(c3_q.table_sel);
  assign wrow  = DIW'(c3_q.row_index);
  assign wcol  = EIW'(c3_q.col_index);
  assign waddr = {t3, DHW'(wrow >> 1), EHW'(wcol >> 1)};
  assign re    = adv && v3_q && (c3_q.kind == ugbi_pkg::KIND_LOOK_1D ||
                                 c3_q.kind == ugbi_pkg::KIND_LOOK_2D);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = 1'(b >> 1);
    localparam logic PC = 1'(b);
    logic [31:0]    mem [2**AW];
    logic [DIW-1:0] rrow;
    logic [EIW-1:0] rcol;
    logic [AW-1:0]  raddr;

    assign rrow  = ix_d3_q + DIW'(ix_d3_q[0] ^ PR);
    assign rcol  = ix_e3_q + EIW'(ix_e3_q[0] ^ PC);
    assign raddr = {t3, DHW'(rrow >> 1), EHW'(rcol >> 1)};
    assign we[b] = adv && v3_q && c3_q.kind == ugbi_pkg::KIND_TABLE_WR &&
                   wrow[0] == PR && wcol[0] == PC;

    always_ff @(posedge clk_i) begin
      if (we[b]) mem[waddr] <= c3_q.write_value;
      if (re) rd_q[b] <= mem[raddr];
    end
  end

  ugbi_pkg::kind_e    k4_q;
  logic [1:0]         a4_q;
  logic               pd4_q, pe4_q;
  ugbi_pkg::frac_t    fr_e4_q, fr_d4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k4_q    <= c3_q.kind;
      a4_q    <= c3_q.action;
      pd4_q   <= ix_d3_q[0];
      pe4_q   <= ix_e3_q[0];
      fr_e4_q <= fr_e3_q;
      fr_d4_q <= fr_d3_q;
    end
  end

  logic signed [31:0] row_lo0, row_lo1, row_hi0, row_hi1, w00, w01, w10, w11;
  assign row_lo0 = pe4_q ? rd_q[1] : rd_q[0];
  assign row_lo1 = pe4_q ? rd_q[0] : rd_q[1];
  assign row_hi0 = pe4_q ? rd_q[3] : rd_q[2];
  assign row_hi1 = pe4_q ? rd_q[2] : rd_q[3];
  assign w00     = pd4_q ? row_hi0 : row_lo0;
  assign w01     = pd4_q ? row_hi1 : row_lo1;
  assign w10     = pd4_q ? row_lo0 : row_hi0;
  assign w11     = pd4_q ? row_lo1 : row_hi1;

  // stages 5 to 12: two lerps along energy, then one along density
  logic signed [31:0] r0, r1, r2;
  logic               vp_q [8];
  ugbi_pkg::kind_e    kp_q [8];
  logic [1:0]         ap_q [8];
  ugbi_pkg::frac_t    fd_q [4];
  logic signed [31:0] r0d_q [4];

  ugbi_lerp u_lerp_lo (.clk_i(clk_i), .en_i(adv), .a_i(w00), .b_i(w01), .f_i(fr_e4_q),
                       .y_o(r0));
  ugbi_lerp u_lerp_hi (.clk_i(clk_i), .en_i(adv), .a_i(w10), .b_i(w11), .f_i(fr_e4_q),
                       .y_o(r1));
  ugbi_lerp u_lerp_d  (.clk_i(clk_i), .en_i(adv), .a_i(r0), .b_i(r1), .f_i(fd_q[3]),
                       .y_o(r2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) vp_q[i] <= 1'b0;
    end else if (adv) begin
      vp_q[0] <= v4_q;
      for (int i = 1; i < 8; i++) vp_q[i] <= vp_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kp_q[0]  <= k4_q;
      ap_q[0]  <= a4_q;
      fd_q[0]  <= fr_d4_q;
      r0d_q[0] <= r0;
      for (int i = 1; i < 8; i++) begin
        kp_q[i] <= kp_q[i-1];
        ap_q[i] <= ap_q[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        fd_q[i]  <= fd_q[i-1];
        r0d_q[i] <= r0d_q[i-1];
      end
    end
  end

  assign res_push_o        = vp_q[7] && adv;
  assign res_o.action_done = ap_q[7];
  assign res_o.result_value = (kp_q[7] == ugbi_pkg::KIND_LOOK_2D) ? r2 :
                              (kp_q[7] == ugbi_pkg::KIND_LOOK_1D) ? r0d_q[3] : 32'sd0;

endmodule

// ===== hdl/uniform_grid_bilinear_interpolator_core.sv =====
// Top level of the uniform grid bilinear interpolator.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------
//   input    | push_i / full_o    | item_i   (ugbi_pkg::in_item_t)
//   result   | empty_o / pop_i    | result_o (ugbi_pkg::out_item_t)
//
// One transaction is taken per cycle while full_o is low; every transaction yields
// one result. From push to result visible it passes through a command queue, a
// twelve-stage engine (offset, multiply, locate, banked table read, three
// four-stage lerps in two ranks) and the result queue.
// Reset restores all geometry; table words are undefined until written.
// A full result queue without pop freezes the whole engine.
module uniform_grid_bilinear_interpolator_core #(
  parameter int NUM_TABLES         = 4,
  parameter int MAX_E_POINTS       = 256,
  parameter int MAX_DENSITY_POINTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  ugbi_pkg::in_item_t  item_i,
  input  logic                pop_i,
  output logic                empty_o,
  output ugbi_pkg::out_item_t result_o
);

  localparam int CW = $bits(ugbi_pkg::cmd_t);
  localparam int OW = $bits(ugbi_pkg::out_item_t);

  ugbi_pkg::cmd_t      cmd_in, cmd_head;
  ugbi_pkg::out_item_t res;
  logic                cmd_empty, cmd_pop, res_full, res_push, res_ready;

  ugbi_front #(
    .NUM_TABLES(NUM_TABLES), .MAX_E_POINTS(MAX_E_POINTS),
    .MAX_DENSITY_POINTS(MAX_DENSITY_POINTS)
  ) u_front (.item_i(item_i), .cmd_o(cmd_in));

  ugbi_fifo #(.WIDTH(CW), .DEPTH(2)) u_cmd_q (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(push_i && !full_o), .data_i(cmd_in), .full_o(full_o),
    .pop_i(cmd_pop), .data_o(cmd_head), .empty_o(cmd_empty)
  );

  assign res_ready = !res_full || (pop_i && !empty_o);

  ugbi_engine #(
    .NUM_TABLES(NUM_TABLES), .MAX_E_POINTS(MAX_E_POINTS),
    .MAX_DENSITY_POINTS(MAX_DENSITY_POINTS)
  ) u_engine (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cmd_i(cmd_head), .cmd_valid_i(!cmd_empty), .cmd_pop_o(cmd_pop),
    .res_ready_i(res_ready), .res_push_o(res_push), .res_o(res)
  );

  ugbi_fifo #(.WIDTH(OW), .DEPTH(2)) u_res_q (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(res_push), .data_i(res), .full_o(res_full),
    .pop_i(pop_i), .data_o(result_o), .empty_o(empty_o)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the uniform grid bilinear interpolator core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         N_TBL      = 4;
  localparam int         E_MAX      = 256;
  localparam int         D_MAX      = 64;
  localparam int         N_RANDOM   = 1500;
  localparam int         HOLD_LEN   = 400;
  localparam int         STALL_LIM  = 4000;
  localparam int         DRAIN_WAIT = 30;
  localparam logic [2:0] GEOM_BAD_6 = 3'd6;
  localparam logic [2:0] GEOM_BAD_7 = 3'd7;
  localparam longint     SAT_MAG    = 64'sd1 << 40;

  typedef struct {
    ugbi_pkg::in_item_t item;
    bit                 typed;
    logic signed [31:0] want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push_i;
  logic                full_o;
  ugbi_pkg::in_item_t  item_i;
  logic                pop_i;
  logic                empty_o;
  ugbi_pkg::out_item_t result_o;

  logic signed [31:0] grid_mem [N_TBL][D_MAX][E_MAX];
  bit                 grid_set [N_TBL][D_MAX][E_MAX];
  longint             ax_org [2*N_TBL];
  longint             ax_inv [2*N_TBL];
  int                 ax_cnt [2*N_TBL];

  ugbi_pkg::out_item_t pending_results[$];
  int                  err_cnt;
  int                  idle_cycles;
  bit                  hold_req;
  dir_row_t            dir_tab[];

  uniform_grid_bilinear_interpolator_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .item_i  (item_i),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic ugbi_pkg::in_item_t mk(logic [1:0] act, logic [1:0] tbl,
                                            logic [5:0] row, logic [7:0] col,
                                            logic [2:0] geom, logic [31:0] wv,
                                            logic [31:0] en, logic [31:0] de);
    ugbi_pkg::in_item_t it;
    it.action      = act;
    it.table_sel   = tbl;
    it.row_index   = row;
    it.col_index   = col;
    it.geom_field  = geom;
    it.write_value = wv;
    it.energy      = en;
    it.density     = de;
    return it;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint f);
    logic signed [127:0] dw, fw, pr;
    dw = 128'(b - a);
    fw = 128'(f);
    pr = (dw * fw) >>> 16;
    if (pr > 128'(SAT_MAG)) pr = 128'(SAT_MAG);
    if (pr < -128'(SAT_MAG)) pr = -128'(SAT_MAG);
    return sat32(a + longint'(pr));
  endfunction

  function automatic void cell_of(longint x, int ax, output int idx, output longint frac);
    longint t, q;
    t = ((x - ax_org[ax]) * ax_inv[ax]) >>> 16;
    if (t < 0) idx = 0;
    else begin
      q = t >>> 16;
      idx = (q > ax_cnt[ax] - 2) ? ax_cnt[ax] - 2 : int'(q);
    end
    frac = t - longint'(idx) * 65536;
  endfunction

  function automatic longint word_of(int tbl, int row, int col);
    return longint'(grid_mem[tbl][row][col]);
  endfunction

  function automatic ugbi_pkg::out_item_t interp_predict(ugbi_pkg::in_item_t it);
    ugbi_pkg::out_item_t r;
    int                  ie, id, k, tb;
    longint              fe, fd, r0, r1, lim;
    r.result_value = '0;
    r.action_done  = it.action;
    tb             = int'(it.table_sel);
    case (it.action)
      ugbi_pkg::ACT_WR_TABLE: begin
        grid_mem[it.table_sel][it.row_index][it.col_index] = it.write_value;
        grid_set[it.table_sel][it.row_index][it.col_index] = 1'b1;
      end
      ugbi_pkg::ACT_WR_GEOM: begin
        k   = 2 * tb + ((it.geom_field >= ugbi_pkg::GEOM_D_ORIGIN) ? 1 : 0);
        lim = (it.geom_field >= ugbi_pkg::GEOM_D_ORIGIN) ? D_MAX : E_MAX;
        case (it.geom_field)
          ugbi_pkg::GEOM_E_ORIGIN, ugbi_pkg::GEOM_D_ORIGIN:
            ax_org[k] = longint'(it.write_value);
          ugbi_pkg::GEOM_E_INV, ugbi_pkg::GEOM_D_INV:
            ax_inv[k] = longint'(it.write_value);
          ugbi_pkg::GEOM_E_LEN, ugbi_pkg::GEOM_D_LEN:
            ax_cnt[k] = (it.write_value < 2) ? 2 :
                        (longint'(it.write_value) > lim) ? int'(lim) : int'(it.write_value);
          default: ;
        endcase
      end
      ugbi_pkg::ACT_LOOK_1D: begin
        cell_of(longint'(it.energy), 2 * tb, ie, fe);
        r.result_value = 32'(lerp_q16(word_of(tb, 0, ie), word_of(tb, 0, ie + 1), fe));
      end
      default: begin
        cell_of(longint'(it.energy), 2 * tb, ie, fe);
        cell_of(longint'(it.density), 2 * tb + 1, id, fd);
        r0 = lerp_q16(word_of(tb, id, ie), word_of(tb, id, ie + 1), fe);
        r1 = lerp_q16(word_of(tb, id + 1, ie), word_of(tb, id + 1, ie + 1), fe);
        r.result_value = 32'(lerp_q16(r0, r1, fd));
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_cnt++;
    $display("tb_top: %0t %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic post_item(ugbi_pkg::in_item_t it, bit typed, logic signed [31:0] want);
    ugbi_pkg::out_item_t r;
    int                  gap;
    push_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    r = interp_predict(it);
    if (typed) r.result_value = want;
    pending_results.push_back(r);
    gap = pick_gap();
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // write any table word the lookup would touch that was never written
  task automatic issue(ugbi_pkg::in_item_t it, bit typed, logic signed [31:0] want);
    int     ie, id, nr, tb;
    longint f;
    tb = int'(it.table_sel);
    if (it.action == ugbi_pkg::ACT_LOOK_1D || it.action == ugbi_pkg::ACT_LOOK_2D) begin
      cell_of(longint'(it.energy), 2 * tb, ie, f);
      id = 0;
      nr = 1;
      if (it.action == ugbi_pkg::ACT_LOOK_2D) begin
        cell_of(longint'(it.density), 2 * tb + 1, id, f);
        nr = 2;
      end
      for (int r = id; r < id + nr; r++)
        for (int c = ie; c < ie + 2; c++)
          if (!grid_set[tb][r][c])
            post_item(mk(ugbi_pkg::ACT_WR_TABLE, it.table_sel, 6'(r), 8'(c),
                         ugbi_pkg::GEOM_E_ORIGIN, $urandom, 32'd0, 32'd0), 1'b0, '0);
    end
    post_item(it, typed, want);
  endtask

  function automatic logic [31:0] near_coord(int ax);
    if ($urandom_range(0, 9) < 2) return $urandom;
    return 32'(ax_org[ax] + longint'($urandom_range(0, 12 * 65536)) - 2 * 65536);
  endfunction

  function automatic ugbi_pkg::in_item_t random_item();
    int          r, tbl;
    logic [2:0]  g;
    logic [31:0] v;
    r   = $urandom_range(0, 99);
    tbl = $urandom_range(0, N_TBL - 1);
    if (r < 12) begin
      g = 3'($urandom_range(0, 7));
      case (g)
        ugbi_pkg::GEOM_E_LEN, ugbi_pkg::GEOM_D_LEN:
          v = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 7)) : $urandom;
        ugbi_pkg::GEOM_E_INV, ugbi_pkg::GEOM_D_INV:
          case ($urandom_range(0, 9))
            0:       v = $urandom;
            1:       v = 32'd0;
            2:       v = -32'(ugbi_pkg::ONE_Q16);
            3, 4, 5: v = ugbi_pkg::ONE_Q16;
            default: v = 32'($urandom_range(16'h4000, 32'h40000));
          endcase
        default:
          v = ($urandom_range(0, 9) < 2) ? $urandom :
              32'($signed($urandom_range(0, 65536 * 40)) - 65536 * 20);
      endcase
      return mk(ugbi_pkg::ACT_WR_GEOM, 2'(tbl), 6'($urandom), 8'($urandom), g, v,
                $urandom, $urandom);
    end
    if (r < 35)
      return mk(ugbi_pkg::ACT_WR_TABLE, 2'(tbl),
                ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                3'($urandom), $urandom, $urandom, $urandom);
    return mk((r < 55) ? ugbi_pkg::ACT_LOOK_1D : ugbi_pkg::ACT_LOOK_2D, 2'(tbl),
              6'($urandom), 8'($urandom), 3'($urandom), $urandom,
              near_coord(2 * tbl), near_coord(2 * tbl + 1));
  endfunction

  initial begin
    push_i   = 1'b0;
    item_i   = '0;
    rst_ni   = 1'b0;
    hold_req = 1'b0;
    err_cnt  = 0;
    for (int k = 0; k < 2 * N_TBL; k++) begin
      ax_org[k] = 0;
      ax_inv[k] = longint'(ugbi_pkg::ONE_Q16);
      ax_cnt[k] = 2;
    end
    dir_tab = '{
      '{mk(ugbi_pkg::ACT_WR_TABLE, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'h7fffffff, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_TABLE, 2'd0, 6'd0, 8'd1, ugbi_pkg::GEOM_E_ORIGIN,
           32'h80000000, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_TABLE, 2'd3, 6'd63, 8'd255, ugbi_pkg::GEOM_E_ORIGIN,
           32'hffffffff, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_LOOK_1D, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'h00008000, 32'd0), 1'b0, 0},
      '{mk(ugbi_pkg::ACT_LOOK_1D, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'h7fffffff, 32'd0), 1'b0, 0},
      '{mk(ugbi_pkg::ACT_LOOK_1D, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'h80000000, 32'd0), 1'b0, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_LEN,
           32'd1000, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_LOOK_1D, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'h7fffffff, 32'd0), 1'b0, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_LEN,
           32'hfffffffb, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd0, 6'd0, 8'd0, GEOM_BAD_6,
           32'd5, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd0, 6'd0, 8'd0, GEOM_BAD_7,
           32'd5, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_INV,
           32'd0, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_LOOK_1D, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'h12345678, 32'd0), 1'b0, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_INV,
           32'hffff0000, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_LOOK_1D, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'hfffe0000, 32'd0), 1'b0, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'h7fffffff, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_INV,
           32'h7fffffff, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_LOOK_1D, 2'd0, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'h80000000, 32'd0), 1'b0, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd3, 6'd0, 8'd0, ugbi_pkg::GEOM_D_LEN,
           32'h7fffffff, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd3, 6'd0, 8'd0, ugbi_pkg::GEOM_E_LEN,
           32'h7fffffff, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd3, 6'd0, 8'd0, ugbi_pkg::GEOM_D_ORIGIN,
           32'h80000000, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_WR_GEOM, 2'd3, 6'd0, 8'd0, ugbi_pkg::GEOM_D_INV,
           32'h00020000, 32'd0, 32'd0), 1'b1, 0},
      '{mk(ugbi_pkg::ACT_LOOK_2D, 2'd3, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'h7fffffff, 32'h7fffffff), 1'b0, 0},
      '{mk(ugbi_pkg::ACT_LOOK_2D, 2'd3, 6'd0, 8'd0, ugbi_pkg::GEOM_E_ORIGIN,
           32'd0, 32'h00018000, 32'h80008000), 1'b0, 0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) issue(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    push_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 800) begin
        push_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      issue(random_item(), 1'b0, '0);
    end
    push_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    int gap;
    pop_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        pop_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          pop_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ugbi_pkg::out_item_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, value",
                        longint'(result_o.result_value), 64'sd0);
      end else begin
        want = pending_results.pop_front();
        if (result_o.result_value !== want.result_value)
          report_mismatch("result_value", longint'(result_o.result_value),
                          longint'(want.result_value));
        if (result_o.action_done !== want.action_done)
          report_mismatch("action_done", longint'(result_o.action_done),
                          longint'(want.action_done));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIM) begin
      $display("tb_top: errors");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

endmodule
